// File: hw/rtl/fih_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the file name hash block.
// No dependencies; every other file of the block refers to this package.
package fih_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // A completed name on its way from the core to the pad stage.
    typedef struct packed {
        logic        mode;     // 1 when the name was hashed in CRC mode
        logic [1:0]  pad_len;  // name length mod 4
        logic [7:0]  head;     // first folded character of the last group
        logic [31:0] acc;      // finished word hash, or the raw CRC register
    } t_pad;

    // ASCII lower case letters become upper case; every other byte passes.
    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // One byte of the reflected CRC-32, one bit per loop step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/fih_core.sv
`timescale 1ns / 1ps
// Input register, mode register and running hash state of the file name hash.
// Uses fih_pkg for the folding and CRC functions and the t_pad type.
module fih_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_in,
    input  logic           i_last_char,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output fih_pkg::t_pad  o_res
);

    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    logic        r_mode;
    logic [31:0] r_acc;
    logic [31:0] r_word;
    logic [1:0]  r_pos;
    logic [7:0]  r_head;

    logic        core_adv;
    logic [7:0]  c;
    logic [1:0]  nxt;
    logic [7:0]  head;
    logic [31:0] crc_new;
    logic [31:0] word;
    logic [31:0] rot_sum;

    // A last character can only leave when the pad stage has room for the name.
    assign core_adv    = r_in_valid && (!r_in_last || i_res_ready);
    assign o_ready     = !r_in_valid || core_adv;
    assign o_res_valid = r_in_valid && r_in_last;

    always_comb begin
        c       = fih_pkg::fold_upper(r_in_char);
        nxt     = r_pos + 2'd1;
        head    = (r_pos == 2'd0) ? c : r_head;
        crc_new = fih_pkg::crc_byte(r_acc, c);
        word    = r_word | ({24'd0, c} << {r_pos, 3'b000});
        rot_sum = {r_acc[30:0], r_acc[31]} + word;

        o_res.mode    = r_mode;
        o_res.pad_len = nxt;
        o_res.head    = head;
        o_res.acc     = r_mode ? crc_new : rot_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_char <= i_char_in;
            r_in_last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_acc  <= 32'd0;
            r_word <= 32'd0;
            r_pos  <= 2'd0;
            r_head <= 8'd0;
        end else if (i_cfg_wr_en) begin
            // A mode change drops any name in progress.
            r_mode <= i_cfg_wr_data;
            r_acc  <= i_cfg_wr_data ? fih_pkg::CRC_INIT : 32'd0;
            r_word <= 32'd0;
            r_pos  <= 2'd0;
            r_head <= 8'd0;
        end else if (core_adv) begin
            if (r_in_last) begin
                r_acc  <= r_mode ? fih_pkg::CRC_INIT : 32'd0;
                r_word <= 32'd0;
                r_pos  <= 2'd0;
                r_head <= 8'd0;
            end else begin
                r_pos  <= nxt;
                r_head <= head;
                if (r_mode) begin
                    r_acc <= crc_new;
                end else if (nxt == 2'd0) begin
                    r_acc  <= rot_sum;
                    r_word <= 32'd0;
                end else begin
                    r_word <= word;
                end
            end
        end
    end

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (core_adv && r_in_last && !i_cfg_wr_en)
        |=> (r_pos == 2'd0 && r_word == 32'd0 && r_head == 8'd0))
        else $error("name state not restarted after the last character");

    a_crc_mode_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode |-> (r_word == 32'd0))
        else $error("word register used in CRC mode");

    a_stalled_char_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !core_adv)
        |=> (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))
        else $error("stalled request lost in the input register");

endmodule

// File: hw/rtl/fih_pad.sv
`timescale 1ns / 1ps
// Pad stage: feeds the CRC pad bytes of a completed name and forms the identifier.
// Uses fih_pkg for crc_byte and the t_pad type.
module fih_pad (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fih_pkg::t_pad  i_res,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_id
);

    logic          r_pad_valid;
    fih_pkg::t_pad r_pad;
    logic [31:0]   crc;

    assign o_ready = !r_pad_valid || i_ready;
    assign o_valid = r_pad_valid;

    // Pad when length mod 4 = n > 0: byte n, then 3 - n copies of the group head.
    always_comb begin
        crc = r_pad.acc;
        if (r_pad.pad_len != 2'd0) begin
            crc = fih_pkg::crc_byte(crc, {6'd0, r_pad.pad_len});
            if (r_pad.pad_len != 2'd3) begin
                crc = fih_pkg::crc_byte(crc, r_pad.head);
            end
            if (r_pad.pad_len == 2'd1) begin
                crc = fih_pkg::crc_byte(crc, r_pad.head);
            end
        end
        o_id = r_pad.mode ? ~crc : r_pad.acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_valid <= 1'b0;
        end else if (o_ready) begin
            r_pad_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pad <= i_res;
        end
    end

endmodule

// File: hw/rtl/filename_id_hash.sv
`timescale 1ns / 1ps
// File name identifier: takes one character per request and returns a 32-bit
// identifier after the request marked last. One character is accepted every
// cycle while the output side takes results; a name's identifier is presented
// on the output once its last character has passed the input register, the pad
// stage register and the output register in turn. The running hash advances one
// character per cycle in the core while it is not stalled; the CRC pad bytes are
// folded in by the pad stage. Write the mode register only while no name is in
// flight; a write drops any partial name.
// Depends on fih_pkg, fih_core and fih_pad.
module filename_id_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_name_id
);

    logic          res_valid;
    logic          res_ready;
    fih_pkg::t_pad res;
    logic          pad_valid;
    logic          pad_ready;
    logic [31:0]   pad_id;

    logic          r_out_valid;
    logic [31:0]   r_out_id;

    fih_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_in     (i_char_in),
        .i_last_char   (i_last_char),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    fih_pad u_pad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (pad_valid),
        .i_ready (pad_ready),
        .o_id    (pad_id)
    );

    assign pad_ready = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_name_id = r_out_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pad_ready) begin
            r_out_valid <= pad_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pad_ready && pad_valid) begin
            r_out_id <= pad_id;
        end
    end

endmodule
